FILE: rtl/imu_complementary_tilt_filter_macros.svh
// ----------------------------------------------------------------------------
// Tilt filter assertion macros
// Concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH

// same-cycle implication
`define ICT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ict_pkg.sv
// ----------------------------------------------------------------------------
// Tilt filter package
// Beat types, sequencer codes and fixed-point constants of the tilt filter.
// ----------------------------------------------------------------------------
package ict_pkg;

  localparam int unsigned ACC_W      = 42;
  localparam int unsigned CW         = 28;
  localparam int unsigned ZW         = 25;
  localparam int unsigned RW         = 48;
  localparam int unsigned MA_W       = 18;
  localparam int unsigned MB_W       = 26;
  localparam int unsigned PROD_W     = MA_W + MB_W;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned SQRT_TOP   = 46;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned QW         = 17;

  localparam logic [9:0] MS_LIMIT = 10'd1000;

  localparam logic signed [MB_W-1:0] LP_GAIN     = 26'sd589824;
  localparam logic signed [MB_W-1:0] RECIP10     = 26'sd6554;
  localparam logic signed [MB_W-1:0] PREV_GAIN   = 26'sd131000;
  localparam logic signed [MB_W-1:0] SMOOTH_GAIN = 26'sd16768000;
  localparam logic signed [MB_W-1:0] FU_RECIP    = 26'sd21486639;
  localparam logic signed [MB_W-1:0] FU_DIV_M    = 26'sd3275000;
  localparam logic [ACC_W-1:0]       FU_DIVISOR  = 42'd3275000;
  localparam logic [ACC_W-1:0]       FU_HALF     = 42'd1637500;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic [9:0]         elapsed_ms;
  } ict_in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } ict_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_A, ST_SQ_B, ST_ROOT, ST_ROT, ST_LP_MUL, ST_LP_DIV,
    ST_FU_PREV, ST_FU_RATE, ST_FU_SCALE, ST_FU_SMOOTH, ST_FU_ROUND,
    ST_DIV, ST_FU_WRITE, ST_DONE
  } ict_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_SQ_A, OP_SQ_B, OP_ROOT, OP_ROT, OP_LP_MUL, OP_LP_DIV,
    OP_FU_PREV, OP_FU_RATE, OP_FU_SCALE, OP_FU_SMOOTH, OP_FU_ROUND,
    OP_DIV, OP_FU_WRITE
  } ict_op_e;

  typedef struct packed {
    ict_op_e           op;
    logic              axis;
    logic [STEP_W-1:0] step;
  } ict_ctrl_t;

  // atan(2^-i) in degrees Q16
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ict_seq.sv
// ----------------------------------------------------------------------------
// Tilt filter sequencer
// Steps the shared datapath through root, rotation, low-pass and fusion
// for the roll axis and then the pitch axis.
// ----------------------------------------------------------------------------
module ict_seq #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  output ict_pkg::ict_ctrl_t ctrl_o,
  output logic              busy_o,
  output logic              load_o
);

  ict_pkg::ict_state_e state_q, state_d;
  logic [ict_pkg::STEP_W-1:0] step_q, step_d;
  logic axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ict_pkg::ST_IDLE;
      step_q  <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    axis_d  = axis_q;
    unique case (state_q)
      ict_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = ict_pkg::ST_SQ_A;
          axis_d  = 1'b0;
        end
      end
      ict_pkg::ST_SQ_A: state_d = ict_pkg::ST_SQ_B;
      ict_pkg::ST_SQ_B: state_d = ict_pkg::ST_ROOT;
      ict_pkg::ST_ROOT: begin
        if (step_q == ict_pkg::STEP_W'(ict_pkg::SQRT_STEPS - 1)) begin
          state_d = ict_pkg::ST_ROT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ict_pkg::ST_ROT: begin
        if (step_q == ict_pkg::STEP_W'(CordicSteps - 1)) begin
          state_d = ict_pkg::ST_LP_MUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ict_pkg::ST_LP_MUL:    state_d = ict_pkg::ST_LP_DIV;
      ict_pkg::ST_LP_DIV:    state_d = ict_pkg::ST_FU_PREV;
      ict_pkg::ST_FU_PREV:   state_d = ict_pkg::ST_FU_RATE;
      ict_pkg::ST_FU_RATE:   state_d = ict_pkg::ST_FU_SCALE;
      ict_pkg::ST_FU_SCALE:  state_d = ict_pkg::ST_FU_SMOOTH;
      ict_pkg::ST_FU_SMOOTH: state_d = ict_pkg::ST_FU_ROUND;
      ict_pkg::ST_FU_ROUND:  state_d = ict_pkg::ST_DIV;
      ict_pkg::ST_DIV: begin
        if (step_q == ict_pkg::STEP_W'(ict_pkg::DIV_STEPS - 1)) begin
          state_d = ict_pkg::ST_FU_WRITE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ict_pkg::ST_FU_WRITE: begin
        if (!axis_q) begin
          state_d = ict_pkg::ST_SQ_A;
          axis_d  = 1'b1;
        end else begin
          state_d = ict_pkg::ST_DONE;
        end
      end
      ict_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = ict_pkg::ST_IDLE;
        end
      end
      default: state_d = ict_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.axis = axis_q;
    ctrl_o.step = step_q;
    busy_o      = (state_q != ict_pkg::ST_IDLE);
    load_o      = (state_q == ict_pkg::ST_DONE) && out_free_i;
    unique case (state_q)
      ict_pkg::ST_SQ_A:      ctrl_o.op = ict_pkg::OP_SQ_A;
      ict_pkg::ST_SQ_B:      ctrl_o.op = ict_pkg::OP_SQ_B;
      ict_pkg::ST_ROOT:      ctrl_o.op = ict_pkg::OP_ROOT;
      ict_pkg::ST_ROT:       ctrl_o.op = ict_pkg::OP_ROT;
      ict_pkg::ST_LP_MUL:    ctrl_o.op = ict_pkg::OP_LP_MUL;
      ict_pkg::ST_LP_DIV:    ctrl_o.op = ict_pkg::OP_LP_DIV;
      ict_pkg::ST_FU_PREV:   ctrl_o.op = ict_pkg::OP_FU_PREV;
      ict_pkg::ST_FU_RATE:   ctrl_o.op = ict_pkg::OP_FU_RATE;
      ict_pkg::ST_FU_SCALE:  ctrl_o.op = ict_pkg::OP_FU_SCALE;
      ict_pkg::ST_FU_SMOOTH: ctrl_o.op = ict_pkg::OP_FU_SMOOTH;
      ict_pkg::ST_FU_ROUND:  ctrl_o.op = ict_pkg::OP_FU_ROUND;
      ict_pkg::ST_DIV:       ctrl_o.op = ict_pkg::OP_DIV;
      ict_pkg::ST_FU_WRITE:  ctrl_o.op = ict_pkg::OP_FU_WRITE;
      default:               ctrl_o.op = ict_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: rtl/ict_dp.sv
// ----------------------------------------------------------------------------
// Tilt filter datapath
// One multiplier, shared by the squaring, low-pass and fusion steps, with
// adders, comparators and barrel shifters for root, CORDIC and division.
// ----------------------------------------------------------------------------
module ict_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ict_pkg::ict_ctrl_t ctrl_i,
  input  ict_pkg::ict_in_t   item_i,
  output ict_pkg::ict_out_t  result_o
);

  localparam int unsigned ACC_W = ict_pkg::ACC_W;
  localparam int unsigned CW    = ict_pkg::CW;
  localparam int unsigned ZW    = ict_pkg::ZW;
  localparam int unsigned RW    = ict_pkg::RW;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [RW-1:0]           rem_q, rem_d, res_q, res_d;
  logic signed [CW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0]    cz_q, cz_d;
  logic                    nz_q, nz_d, neg_q, neg_d;
  logic [ict_pkg::QW-1:0]  qd_q, qd_d;
  logic signed [8:0]       sr_q, sr_d, sp_q, sp_d;
  logic signed [15:0]      fr_q, fr_d, fp_q, fp_d;

  logic signed [ict_pkg::MA_W-1:0]   mul_a;
  logic signed [ict_pkg::MB_W-1:0]   mul_b;
  logic signed [ict_pkg::PROD_W-1:0] prod;

  logic signed [16:0] num;
  logic signed [15:0] opa, rate;
  logic signed [8:0]  smooth;
  logic signed [15:0] fused;
  logic [9:0]         ms;

  logic [RW-1:0]           rem_cur, res_cur, root_bit, root_try;
  logic [5:0]              root_sh;
  logic signed [CW-1:0]    x_cur, xs, ys;
  logic signed [ZW-1:0]    atan_v;
  logic                    lp_neg;
  logic [ACC_W-1:0]        lp_mag;
  logic [11:0]             lp_t;
  logic signed [10:0]      lp_v;
  logic signed [8:0]       lp_sat;
  logic signed [17:0]      fu_neg;
  logic signed [15:0]      fu_sat;

  assign num    = ctrl_i.axis ? -17'(item_i.accel_x) : 17'(item_i.accel_y);
  assign opa    = ctrl_i.axis ? item_i.accel_y : item_i.accel_x;
  assign rate   = ctrl_i.axis ? item_i.rate_y : item_i.rate_x;
  assign smooth = ctrl_i.axis ? sp_q : sr_q;
  assign fused  = ctrl_i.axis ? fp_q : fr_q;
  assign ms     = item_i.elapsed_ms;

  assign lp_neg = acc_q[ACC_W-1];
  assign lp_mag = lp_neg ? $unsigned(-acc_q) : $unsigned(acc_q);
  assign lp_t   = lp_mag[27:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      ict_pkg::OP_SQ_A: begin
        mul_a = 18'(opa);
        mul_b = 26'(opa);
      end
      ict_pkg::OP_SQ_B: begin
        mul_a = 18'(item_i.accel_z);
        mul_b = 26'(item_i.accel_z);
      end
      ict_pkg::OP_LP_MUL: begin
        mul_a = 18'(smooth);
        mul_b = ict_pkg::LP_GAIN;
      end
      ict_pkg::OP_LP_DIV: begin
        mul_a = $signed({6'b0, lp_t});
        mul_b = ict_pkg::RECIP10;
      end
      ict_pkg::OP_FU_PREV: begin
        mul_a = 18'(fused);
        mul_b = ict_pkg::PREV_GAIN;
      end
      ict_pkg::OP_FU_RATE: begin
        mul_a = 18'(rate);
        mul_b = $signed({16'b0, ms});
      end
      ict_pkg::OP_FU_SMOOTH: begin
        mul_a = 18'(smooth);
        mul_b = ict_pkg::SMOOTH_GAIN;
      end
      ict_pkg::OP_DIV: begin
        if (ctrl_i.step == '0) begin
          mul_a = $signed({1'b0, acc_q[37:21]});
          mul_b = ict_pkg::FU_RECIP;
        end else begin
          mul_a = $signed({1'b0, qd_q});
          mul_b = ict_pkg::FU_DIV_M;
        end
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rem_cur  = (ctrl_i.step == '0) ? {acc_q[31:0], 16'h0} : rem_q;
  assign res_cur  = (ctrl_i.step == '0) ? '0 : res_q;
  assign root_sh  = 6'(ict_pkg::SQRT_TOP) - {ctrl_i.step, 1'b0};
  assign root_bit = RW'(1) << root_sh;
  assign root_try = res_cur + root_bit;

  assign x_cur  = (ctrl_i.step == '0) ? $signed(res_q[CW-1:0]) : cx_q;
  assign xs     = x_cur >>> ctrl_i.step;
  assign ys     = cy_q >>> ctrl_i.step;
  assign atan_v = $signed({3'b0, ict_pkg::atan_q16(ctrl_i.step)});

  assign lp_v   = lp_neg ? -$signed({2'b0, prod[24:16]}) : $signed({2'b0, prod[24:16]});
  assign lp_sat = (lp_v > 11'sd255) ? 9'sd255 :
                  (lp_v < -11'sd256) ? -9'sd256 : 9'(lp_v);

  assign fu_neg = -$signed({1'b0, qd_q});
  assign fu_sat = neg_q ? ((qd_q > 17'd32768) ? -16'sd32768 : 16'(fu_neg))
                        : ((qd_q > 17'd32767) ? 16'sd32767 : 16'(qd_q));

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    res_d = res_q;
    cx_d  = cx_q;
    cy_d  = cy_q;
    cz_d  = cz_q;
    nz_d  = nz_q;
    neg_d = neg_q;
    qd_d  = qd_q;
    sr_d  = sr_q;
    sp_d  = sp_q;
    fr_d  = fr_q;
    fp_d  = fp_q;
    unique case (ctrl_i.op)
      ict_pkg::OP_SQ_A: begin
        acc_d = ACC_W'(prod);
        nz_d  = (num == '0);
        cy_d  = CW'(num) <<< 8;
        cz_d  = '0;
      end
      ict_pkg::OP_SQ_B: acc_d = acc_q + ACC_W'(prod);
      ict_pkg::OP_ROOT: begin
        if (rem_cur >= root_try) begin
          rem_d = rem_cur - root_try;
          res_d = (res_cur >> 1) + root_bit;
        end else begin
          rem_d = rem_cur;
          res_d = res_cur >> 1;
        end
      end
      ict_pkg::OP_ROT: begin
        if (cy_q > 0) begin
          cx_d = x_cur + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + atan_v;
        end else begin
          cx_d = x_cur - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - atan_v;
        end
      end
      ict_pkg::OP_LP_MUL: acc_d = ACC_W'(prod) + (nz_q ? '0 : ACC_W'(cz_q));
      ict_pkg::OP_LP_DIV: begin
        if (ctrl_i.axis) begin
          sp_d = lp_sat;
        end else begin
          sr_d = lp_sat;
        end
      end
      ict_pkg::OP_FU_PREV:   acc_d = ACC_W'(prod);
      ict_pkg::OP_FU_RATE:   acc_d = acc_q + (ACC_W'(prod) <<< 7);
      ict_pkg::OP_FU_SCALE:  acc_d = (acc_q <<< 4) + (acc_q <<< 3);
      ict_pkg::OP_FU_SMOOTH: acc_d = acc_q + ACC_W'(prod);
      ict_pkg::OP_FU_ROUND: begin
        neg_d = acc_q[ACC_W-1];
        acc_d = $signed(lp_mag + ict_pkg::FU_HALF);
        qd_d  = '0;
      end
      ict_pkg::OP_DIV: begin
        if (ctrl_i.step == '0) begin
          qd_d = prod[41:25];
        end else if (ctrl_i.step == ict_pkg::STEP_W'(1)) begin
          acc_d = acc_q - ACC_W'(prod);
        end else if ($unsigned(acc_q) >= ict_pkg::FU_DIVISOR) begin
          acc_d = acc_q - $signed(ict_pkg::FU_DIVISOR);
          qd_d  = qd_q + 1'b1;
        end
      end
      ict_pkg::OP_FU_WRITE: begin
        if (ctrl_i.axis) begin
          fp_d = fu_sat;
        end else begin
          fr_d = fu_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    res_q <= res_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cz_q  <= cz_d;
    nz_q  <= nz_d;
    neg_q <= neg_d;
    qd_q  <= qd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= '0;
      sp_q <= '0;
      fr_q <= '0;
      fp_q <= '0;
    end else begin
      sr_q <= sr_d;
      sp_q <= sp_d;
      fr_q <= fr_d;
      fp_q <= fp_d;
    end
  end

  assign result_o.roll_angle  = fr_q;
  assign result_o.pitch_angle = fp_q;

endmodule

FILE: rtl/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// IMU complementary tilt filter
// Accelerometer tilt by square root and CORDIC, whole-degree low-pass, and
// fusion with integrated gyro rate into Q9.7 roll and pitch.
//
//   beat     dir  valid        stall         payload
//   sample   in   in_valid_i   in_stall_o    in_data_i  (ict_in_t)
//   angles   out  out_valid_o  out_stall_i   out_data_o (ict_out_t)
//
// Each sample runs the 24-step square root, the CORDIC loop and the
// three-step reciprocal division on one shared datapath, once per axis.
// in_stall_o stays high from accept until the result enters the output
// register; a stalled result holds and only delays the end of the sample.
// Reset clears the filter state to zero angles.
// ----------------------------------------------------------------------------
`include "imu_complementary_tilt_filter_macros.svh"

module imu_complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ict_pkg::ict_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ict_pkg::ict_out_t out_data_o
);

  ict_pkg::ict_in_t   item_q, in_clip;
  ict_pkg::ict_out_t  out_q, result;
  ict_pkg::ict_ctrl_t ctrl;
  logic out_vld_q, busy, load, in_acc, out_free;

  assign in_acc     = in_valid_i && !busy;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = busy;

  always_comb begin
    in_clip = in_data_i;
    if (in_data_i.elapsed_ms > ict_pkg::MS_LIMIT) begin
      in_clip.elapsed_ms = ict_pkg::MS_LIMIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_clip;
    end
    if (load) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  ict_seq #(
    .CordicSteps(CORDIC_STEPS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .out_free_i(out_free),
    .ctrl_o    (ctrl),
    .busy_o    (busy),
    .load_o    (load)
  );

  ict_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .item_i  (item_q),
    .result_o(result)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `ICT_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")
  `ICT_ASSERT_IMP(a_result_on_finish, $fell(in_stall_o), out_valid_o, "finished without result")
  `ICT_ASSERT_NXT(a_no_phantom_result, out_valid_o && !out_stall_i, !out_valid_o || $past(in_stall_o), "result without sample")

endmodule
